>>> hdl/fpsum_pkg.sv
// ----------------------------------------------------------------------------
// fpsum_pkg
// Shared types and constants of the frame parser with additive checksum.
// ----------------------------------------------------------------------------
package fpsum_pkg;

  // Frame status codes carried on a status result.
  localparam logic [2:0] STATUS_OK        = 3'd0;
  localparam logic [2:0] STATUS_TOO_SHORT = 3'd1;
  localparam logic [2:0] STATUS_BAD_START = 3'd2;
  localparam logic [2:0] STATUS_BAD_TYPE  = 3'd3;
  localparam logic [2:0] STATUS_BAD_SUM   = 3'd4;

  // Result kinds.
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_START_WORD = 1'b0;
  localparam logic CFG_TYPE_COUNT = 1'b1;

  // One result item.
  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [2:0]  status;
    logic [7:0]  frame_type;
    logic [7:0]  dest_addr;
    logic [7:0]  source_addr;
    logic [15:0] sequence_num;
    logic [7:0]  payload_count;
  } result_t;

endpackage

>>> hdl/fpsum_core.sv
// ----------------------------------------------------------------------------
// fpsum_core
// Frame state registers and the combinational parse of each accepted byte.
// ----------------------------------------------------------------------------
module fpsum_core import fpsum_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [7:0]  data_byte,
  input  logic        buffer_end,
  input  logic [15:0] start_word,
  input  logic [7:0]  type_count,
  output logic        res_valid,
  output result_t     res
);

  // Byte positions within the frame header.
  localparam logic [8:0] POS_START_HI = 9'd0;
  localparam logic [8:0] POS_START_LO = 9'd1;
  localparam logic [8:0] POS_LENGTH   = 9'd2;
  localparam logic [8:0] POS_TYPE     = 9'd3;
  localparam logic [8:0] POS_DEST     = 9'd4;
  localparam logic [8:0] POS_SOURCE   = 9'd5;
  localparam logic [8:0] POS_SEQ_HI   = 9'd6;
  localparam logic [8:0] POS_SEQ_LO   = 9'd7;
  localparam logic [8:0] POS_PAYLOAD  = 9'd8;
  localparam logic [8:0] POS_MIN_END  = 9'd9;
  localparam logic [8:0] POS_MAX      = 9'd511;

  logic [8:0]  byte_pos,    byte_pos_next;
  logic [15:0] start_seen,  start_seen_next;
  logic [7:0]  length_reg,  length_reg_next;
  logic [7:0]  type_reg,    type_reg_next;
  logic [7:0]  dest_reg,    dest_reg_next;
  logic [7:0]  source_reg,  source_reg_next;
  logic [15:0] seq_reg,     seq_reg_next;
  logic [15:0] running_sum, running_sum_next;
  logic [7:0]  check_high,  check_high_next;
  logic        frame_done,  frame_done_next;

  logic [8:0]  chk_pos;
  logic [15:0] got_sum;
  logic        start_ok;
  logic        status_hit;
  logic [2:0]  status_code;

  // Parse one byte against the current frame state.
  always_comb begin
    byte_pos_next    = byte_pos;
    start_seen_next  = start_seen;
    length_reg_next  = length_reg;
    type_reg_next    = type_reg;
    dest_reg_next    = dest_reg;
    source_reg_next  = source_reg;
    seq_reg_next     = seq_reg;
    running_sum_next = running_sum;
    check_high_next  = check_high;
    frame_done_next  = frame_done;
    res_valid        = 1'b0;
    res              = '0;
    status_hit       = 1'b0;
    status_code      = STATUS_OK;
    chk_pos          = POS_PAYLOAD + {1'b0, length_reg};
    got_sum          = {check_high, data_byte};
    start_ok         = 1'b0;

    if (in_valid && !frame_done) begin
      // Capture header fields by position.
      unique case (byte_pos)
        POS_START_HI: start_seen_next = {data_byte, 8'h00};
        POS_START_LO: start_seen_next = {start_seen[15:8], data_byte};
        POS_LENGTH: begin
          length_reg_next = data_byte;
          chk_pos         = POS_PAYLOAD + {1'b0, data_byte};
        end
        POS_TYPE:     type_reg_next   = data_byte;
        POS_DEST:     dest_reg_next   = data_byte;
        POS_SOURCE:   source_reg_next = data_byte;
        POS_SEQ_HI:   seq_reg_next    = {data_byte, 8'h00};
        POS_SEQ_LO:   seq_reg_next    = {seq_reg[15:8], data_byte};
        default: ;
      endcase

      // Checksum accumulation and capture of the checksum high byte.
      if (byte_pos < chk_pos) begin
        running_sum_next = running_sum + {8'h00, data_byte};
      end else if (byte_pos == chk_pos) begin
        check_high_next = data_byte;
      end

      start_ok = (start_seen_next == start_word);

      // Decide the result of this byte, status first.
      if (byte_pos == POS_MIN_END && !start_ok) begin
        status_hit  = 1'b1;
        status_code = STATUS_BAD_START;
      end else if (byte_pos >= POS_MIN_END && byte_pos == chk_pos + 9'd1) begin
        status_hit = 1'b1;
        if (!start_ok) begin
          status_code = STATUS_BAD_START;
        end else if (type_reg_next >= type_count) begin
          status_code = STATUS_BAD_TYPE;
        end else if (got_sum != running_sum_next) begin
          status_code = STATUS_BAD_SUM;
        end else begin
          status_code = STATUS_OK;
        end
      end else if (buffer_end) begin
        status_hit  = 1'b1;
        status_code = STATUS_TOO_SHORT;
      end else if (byte_pos >= POS_PAYLOAD && byte_pos < chk_pos && start_ok) begin
        res_valid        = 1'b1;
        res.kind         = KIND_PAYLOAD;
        res.payload_byte = data_byte;
      end

      if (status_hit) begin
        res_valid         = 1'b1;
        res.kind          = KIND_STATUS;
        res.status        = status_code;
        res.frame_type    = type_reg_next;
        res.dest_addr     = dest_reg_next;
        res.source_addr   = source_reg_next;
        res.sequence_num  = seq_reg_next;
        res.payload_count = length_reg_next;
        frame_done_next   = 1'b1;
      end

      if (byte_pos != POS_MAX) begin
        byte_pos_next = byte_pos + 9'd1;
      end
    end

    // The buffer's last byte always starts a fresh frame.
    if (in_valid && buffer_end) begin
      byte_pos_next    = '0;
      start_seen_next  = '0;
      length_reg_next  = '0;
      type_reg_next    = '0;
      dest_reg_next    = '0;
      source_reg_next  = '0;
      seq_reg_next     = '0;
      running_sum_next = '0;
      check_high_next  = '0;
      frame_done_next  = 1'b0;
    end
  end

  // Frame state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos    <= '0;
      start_seen  <= '0;
      length_reg  <= '0;
      type_reg    <= '0;
      dest_reg    <= '0;
      source_reg  <= '0;
      seq_reg     <= '0;
      running_sum <= '0;
      check_high  <= '0;
      frame_done  <= 1'b0;
    end else begin
      byte_pos    <= byte_pos_next;
      start_seen  <= start_seen_next;
      length_reg  <= length_reg_next;
      type_reg    <= type_reg_next;
      dest_reg    <= dest_reg_next;
      source_reg  <= source_reg_next;
      seq_reg     <= seq_reg_next;
      running_sum <= running_sum_next;
      check_high  <= check_high_next;
      frame_done  <= frame_done_next;
    end
  end

endmodule

>>> hdl/fpsum_skid.sv
// ----------------------------------------------------------------------------
// fpsum_skid
// Output register with one skid entry, so the input ready is registered.
// ----------------------------------------------------------------------------
module fpsum_skid import fpsum_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  result_t in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    skid_valid;
  result_t skid_data;

  assign in_ready = !skid_valid;

  // Results move to the output register; a stalled transfer parks in the skid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_valid;
      end
    end else if (in_valid && in_ready) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (in_valid) begin
        out_data <= in_data;
      end
    end else if (in_valid && in_ready) begin
      skid_data <= in_data;
    end
  end

endmodule

>>> hdl/frame_parser_with_sum_checksum.sv
// ----------------------------------------------------------------------------
// frame_parser_with_sum_checksum
// Byte-stream deframer with a 16-bit additive checksum.
// ----------------------------------------------------------------------------
// Usage:
// Receive-buffer bytes enter on the s_axis channel, one per transfer, with
// s_axis_tlast on the buffer's last byte. Each frame yields its payload
// bytes (m_axis_tuser = 0) followed by one status result (m_axis_tuser = 1)
// carrying the status code and the parsed header fields. Bytes after the
// status are dropped until the buffer ends.
// The configuration port sets the expected start word (index 0) and the
// number of valid frame types (index 1); write it only while the block idles.
// Throughput is one byte per cycle while s_axis_tready is high. Each result
// reaches m_axis from a register; each byte passes through one parse step between
// the frame state registers and the output register.
// When the receiver stalls, one extra result is held in a skid entry and
// s_axis_tready drops until the output drains.
// Reset clears all frame state, sets start word 0 and type count 255, and
// empties the output stage.
// ----------------------------------------------------------------------------
module frame_parser_with_sum_checksum import fpsum_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // Configuration write port
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // buffer_end
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] payload_byte, [10:8] status, [18:11] frame_type, [26:19] dest_addr,
  // [34:27] source_addr, [50:35] sequence_num, [58:51] payload_count, rest 0
  output logic [63:0] m_axis_tdata,
  output logic        m_axis_tuser    // kind
);

  logic [15:0] start_word;
  logic [7:0]  type_count;
  logic        in_xfer;
  logic        res_valid;
  result_t     res;
  result_t     out_res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_word <= 16'h0000;
      type_count <= 8'hFF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_WORD: start_word <= cfg_data;
        CFG_TYPE_COUNT: type_count <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign in_xfer = s_axis_tvalid && s_axis_tready;

  fpsum_core u_core (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_xfer),
    .data_byte  (s_axis_tdata),
    .buffer_end (s_axis_tlast),
    .start_word (start_word),
    .type_count (type_count),
    .res_valid  (res_valid),
    .res        (res)
  );

  fpsum_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_ready  (s_axis_tready),
    .in_data   (res),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_res)
  );

  // Pack the result fields, lowest field first.
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tdata = {5'b00000,
                         out_res.payload_count,
                         out_res.sequence_num,
                         out_res.source_addr,
                         out_res.dest_addr,
                         out_res.frame_type,
                         out_res.status,
                         out_res.payload_byte};

endmodule
